// ===== hdl/assert_macros.svh =====
// assertion helpers included by the engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SAS_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SAS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sas_pkg.sv =====
package sas_pkg;

  // fixed field widths
  localparam int OP_W       = 1;
  localparam int TR_W       = 4;
  localparam int FIRST_W    = 12;
  localparam int SPAN_W     = 13;
  localparam int WORD_BITS  = 64;
  localparam int OFFS_W     = 6;
  // start_pkt + span, and word index of any packet in that sum
  localparam int SUM_W      = 14;
  localparam int WIDX_W     = 8;

  typedef enum logic [OP_W-1:0] {
    OP_MARK  = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_RD0,
    ST_MARK_WR0,
    ST_MARK_RD1,
    ST_MARK_WR1,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [TR_W-1:0]       transfer;
    logic [FIRST_W-1:0]    start_pkt;
    logic [SPAN_W-1:0]     span;
    logic [WORD_BITS-1:0]  ack_bits;
  } req_t;

  typedef struct packed {
    logic status;
    logic range_acked;
  } res_t;

endpackage

// ===== hdl/selective_ack_scoreboard.sv =====
// an error, an empty check or a mark with no bit to set goes from idle straight to the done state
// a mark does one read-modify-write per word that it writes, one word or two
// a check reads one store word per cycle and stops early on the first missing packet
// one item in work at a time; the next beat is taken the cycle after the result is registered
// reset clears control at once, then the clear state zeroes all NUM_TRANSFERS * ceil(MAX_PACKETS / 64)
// store words while in_stall_o stays high
module selective_ack_scoreboard #(
  parameter int NUM_TRANSFERS = 16,
  parameter int MAX_PACKETS   = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sas_pkg::OP_W-1:0]        op_i,
  input  logic [sas_pkg::TR_W-1:0]        transfer_i,
  input  logic [sas_pkg::FIRST_W-1:0]     start_pkt_i,
  input  logic [sas_pkg::SPAN_W-1:0]      span_i,
  input  logic [sas_pkg::WORD_BITS-1:0]   ack_bits_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            status_o,
  output logic                            range_acked_o
);

  localparam int WORDS_PER_TR = (MAX_PACKETS + sas_pkg::WORD_BITS - 1) / sas_pkg::WORD_BITS;
  localparam int DEPTH        = NUM_TRANSFERS * WORDS_PER_TR;
  localparam int AW           = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sas_pkg::req_t                 req;
  sas_pkg::res_t                 res;
  logic                          req_ready;
  logic                          res_valid;
  logic                          res_take;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [sas_pkg::WORD_BITS-1:0] mem_wdata;
  logic                          mem_re;
  logic [AW-1:0]                 mem_raddr;
  logic [sas_pkg::WORD_BITS-1:0] mem_rdata;
  logic                          out_valid_q, out_valid_d;
  logic                          status_q;
  logic                          acked_q;

  // input beat into request struct
  always_comb begin
    req.op        = sas_pkg::op_e'(op_i);
    req.transfer  = transfer_i;
    req.start_pkt = start_pkt_i;
    req.span      = span_i;
    req.ack_bits  = ack_bits_i;
  end

  assign in_stall_o = !req_ready;

  sas_engine #(
    .NUM_TRANSFERS (NUM_TRANSFERS),
    .MAX_PACKETS   (MAX_PACKETS),
    .DEPTH         (DEPTH),
    .AW            (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .req_ready_o (req_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sas_ack_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res.status;
      acked_q  <= res.range_acked;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign range_acked_o = acked_q;

endmodule

// ===== hdl/sas_ack_mem.sv =====
module sas_ack_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [sas_pkg::WORD_BITS-1:0]  wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [sas_pkg::WORD_BITS-1:0]  rdata_o
);

  logic [sas_pkg::WORD_BITS-1:0] store_q [DEPTH];
  logic [sas_pkg::WORD_BITS-1:0] rdata_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sas_engine.sv =====
module sas_engine #(
  parameter int NUM_TRANSFERS = 16,
  parameter int MAX_PACKETS   = 4096,
  parameter int DEPTH         = 1024,
  parameter int AW            = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  sas_pkg::req_t                  req_i,
  output logic                           req_ready_o,
  output logic                           res_valid_o,
  output sas_pkg::res_t                  res_o,
  input  logic                           res_ready_i,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [sas_pkg::WORD_BITS-1:0]  mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [sas_pkg::WORD_BITS-1:0]  mem_rdata_i
);

  localparam int WB           = sas_pkg::WORD_BITS;
  localparam int WORDS_PER_TR = (MAX_PACKETS + WB - 1) / WB;
  localparam int FULL_WORDS   = MAX_PACKETS / WB;
  localparam int REM_BITS     = MAX_PACKETS % WB;
  localparam logic [WB-1:0] ONES      = {WB{1'b1}};
  localparam logic [WB-1:0] PART_MASK = (REM_BITS == 0) ? '0 : (ONES >> (WB - REM_BITS));

  // bits of word w that belong to packets below capacity
  function automatic logic [WB-1:0] word_mask(input logic [sas_pkg::WIDX_W-1:0] w);
    logic [WB-1:0] m;
    m = '0;
    if (32'(w) < FULL_WORDS) begin
      m = ONES;
    end else if (32'(w) == FULL_WORDS) begin
      m = PART_MASK;
    end
    return m;
  endfunction

  sas_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            cmp_vld_q, cmp_vld_d;

  logic [AW-1:0]                  base_q, base_d;
  logic [AW-1:0]                  addr0_q, addr0_d;
  logic [AW-1:0]                  addr1_q, addr1_d;
  logic [WB-1:0]                  data0_q, data0_d;
  logic [WB-1:0]                  data1_q, data1_d;
  logic                           status_q, status_d;
  logic                           acked_q, acked_d;
  logic [sas_pkg::WIDX_W-1:0]     wf_q, wf_d;
  logic [sas_pkg::WIDX_W-1:0]     wl_q, wl_d;
  logic [sas_pkg::OFFS_W-1:0]     lo_q, lo_d;
  logic [sas_pkg::OFFS_W-1:0]     hi_q, hi_d;
  logic [sas_pkg::WIDX_W-1:0]     iss_q, iss_d;
  logic [sas_pkg::WIDX_W-1:0]     cmp_w_q, cmp_w_d;

  // decode of the incoming beat
  logic                        tr_bad;
  logic [sas_pkg::SUM_W-1:0]   sum;
  logic [sas_pkg::SUM_W-1:0]   last_pkt;
  logic                        past;
  logic                        over_limit;
  logic [sas_pkg::WIDX_W-1:0]  w0;
  logic [sas_pkg::WIDX_W-1:0]  w1;
  logic [sas_pkg::WIDX_W-1:0]  wl;
  logic [WB-1:0]               span_mask;
  logic [2*WB-1:0]             shifted;
  logic [WB-1:0]               in_d0;
  logic [WB-1:0]               in_d1;
  logic [AW-1:0]               in_base;
  logic [WB-1:0]               cmp_mask;
  logic                        cmp_pass;

  always_comb begin
    tr_bad     = 32'(req_i.transfer) >= NUM_TRANSFERS;
    sum        = sas_pkg::SUM_W'(req_i.start_pkt) + sas_pkg::SUM_W'(req_i.span);
    last_pkt   = sum - sas_pkg::SUM_W'(1);
    past       = 32'(sum) > 32'(MAX_PACKETS);
    over_limit = |req_i.span[sas_pkg::SPAN_W-1:sas_pkg::OFFS_W] &&
                 (req_i.span != sas_pkg::SPAN_W'(WB));
    w0         = sas_pkg::WIDX_W'(req_i.start_pkt >> sas_pkg::OFFS_W);
    w1         = w0 + sas_pkg::WIDX_W'(1);
    wl         = sas_pkg::WIDX_W'(last_pkt >> sas_pkg::OFFS_W);
    // keep only the first min(span, 64) mark bits
    if (|req_i.span[sas_pkg::SPAN_W-1:sas_pkg::OFFS_W]) begin
      span_mask = ONES;
    end else begin
      span_mask = (WB'(1) << req_i.span[sas_pkg::OFFS_W-1:0]) - WB'(1);
    end
    shifted = {{WB{1'b0}}, req_i.ack_bits & span_mask}
              << req_i.start_pkt[sas_pkg::OFFS_W-1:0];
    in_d0   = shifted[WB-1:0] & word_mask(w0);
    in_d1   = shifted[2*WB-1:WB] & word_mask(w1);
    in_base = AW'(32'(req_i.transfer) * WORDS_PER_TR);
  end

  // range mask of the word under comparison
  always_comb begin
    cmp_mask = (ONES << ((cmp_w_q == wf_q) ? lo_q : '0)) &
               (ONES >> ((cmp_w_q == wl_q) ? ~hi_q : '0));
    cmp_pass = (mem_rdata_i & cmp_mask) == cmp_mask;
  end

  // control and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sas_pkg::ST_CLEAR;
      clr_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    addr0_q  <= addr0_d;
    addr1_q  <= addr1_d;
    data0_q  <= data0_d;
    data1_q  <= data1_d;
    status_q <= status_d;
    acked_q  <= acked_d;
    wf_q     <= wf_d;
    wl_q     <= wl_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    iss_q    <= iss_d;
    cmp_w_q  <= cmp_w_d;
  end

  // next state and memory control
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    base_d      = base_q;
    addr0_d     = addr0_q;
    addr1_d     = addr1_q;
    data0_d     = data0_q;
    data1_d     = data1_q;
    status_d    = status_q;
    acked_d     = acked_q;
    wf_d        = wf_q;
    wl_d        = wl_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    iss_d       = iss_q;
    cmp_w_d     = iss_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = addr0_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr0_q;

    case (state_q)
      sas_pkg::ST_CLEAR: begin
        // zero one word per cycle after reset
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = sas_pkg::ST_IDLE;
        end
      end

      sas_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        base_d      = in_base;
        addr0_d     = AW'(32'(in_base) + 32'(w0));
        addr1_d     = AW'(32'(in_base) + 32'(w1));
        data0_d     = in_d0;
        data1_d     = in_d1;
        wf_d        = w0;
        wl_d        = wl;
        lo_d        = req_i.start_pkt[sas_pkg::OFFS_W-1:0];
        hi_d        = last_pkt[sas_pkg::OFFS_W-1:0];
        iss_d       = w0;
        status_d    = 1'b0;
        acked_d     = 1'b0;
        if (req_valid_i) begin
          if (tr_bad) begin
            status_d = 1'b1;
            state_d  = sas_pkg::ST_DONE;
          end else if (req_i.op == sas_pkg::OP_MARK) begin
            status_d = over_limit || past;
            if (in_d0 != '0) begin
              state_d = sas_pkg::ST_MARK_RD0;
            end else if (in_d1 != '0) begin
              state_d = sas_pkg::ST_MARK_RD1;
            end else begin
              state_d = sas_pkg::ST_DONE;
            end
          end else if (past) begin
            status_d = 1'b1;
            state_d  = sas_pkg::ST_DONE;
          end else begin
            acked_d = 1'b1;
            if (req_i.span == '0) begin
              state_d = sas_pkg::ST_DONE;
            end else begin
              state_d = sas_pkg::ST_CHECK;
            end
          end
        end
      end

      sas_pkg::ST_MARK_RD0: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr0_q;
        state_d     = sas_pkg::ST_MARK_WR0;
      end

      sas_pkg::ST_MARK_WR0: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr0_q;
        mem_wdata_o = mem_rdata_i | data0_q;
        state_d     = (data1_q != '0) ? sas_pkg::ST_MARK_RD1 : sas_pkg::ST_DONE;
      end

      sas_pkg::ST_MARK_RD1: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = addr1_q;
        state_d     = sas_pkg::ST_MARK_WR1;
      end

      sas_pkg::ST_MARK_WR1: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = addr1_q;
        mem_wdata_o = mem_rdata_i | data1_q;
        state_d     = sas_pkg::ST_DONE;
      end

      sas_pkg::ST_CHECK: begin
        // read one word per cycle, compare it in the cycle after
        if (iss_q <= wl_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(32'(base_q) + 32'(iss_q));
          iss_d       = iss_q + sas_pkg::WIDX_W'(1);
        end
        if (cmp_vld_q) begin
          if (!cmp_pass) begin
            acked_d = 1'b0;
            state_d = sas_pkg::ST_DONE;
          end else if (cmp_w_q == wl_q) begin
            state_d = sas_pkg::ST_DONE;
          end
        end
      end

      sas_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sas_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = sas_pkg::ST_IDLE;
      end
    endcase

    cmp_vld_d = mem_re_o && (state_q == sas_pkg::ST_CHECK);
  end

  assign res_o.status      = status_q;
  assign res_o.range_acked = acked_q;

`include "assert_macros.svh"

  `SAS_ASSERT_IMPL(a_no_rw_collide, clk_i, rst_ni, mem_we_o && mem_re_o, mem_waddr_o != mem_raddr_o, "read and write hit one word in one cycle")
  `SAS_ASSERT_IMPL(a_rmw_addr, clk_i, rst_ni, state_q == sas_pkg::ST_MARK_WR0, $past(mem_re_o) && ($past(mem_raddr_o) == mem_waddr_o), "mark write-back without matching read")
  `SAS_ASSERT_IMPL(a_cmp_has_read, clk_i, rst_ni, cmp_vld_q, $past(mem_re_o), "compare without a read in the previous cycle")
  `SAS_ASSERT_NEXT(a_idle_after_result, clk_i, rst_ni, res_valid_o && res_ready_i, req_ready_o, "engine not ready after result handover")

endmodule

// ===== test/ack_tb_pkg.sv =====
package ack_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_TR   = 16;
  localparam int PKTS     = 4096;
  localparam int WORDS    = PKTS / sas_pkg::WORD_BITS;
  localparam int MARK_MAX = 64;
  localparam int MAX_LOG  = 100;

  // acknowledgment bitmap predictor and the answers it still waits for
  class sack_predictor;
    logic [sas_pkg::WORD_BITS-1:0] bitmap [NUM_TR][WORDS];
    sas_pkg::res_t                 expected_answers [$];
    int unsigned                   fails;
    int unsigned                   answers_seen;

    function new();
      foreach (bitmap[t, w]) bitmap[t][w] = '0;
      expected_answers.delete();
      fails        = 0;
      answers_seen = 0;
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction

    // apply an accepted input beat and queue the answer it must produce
    function void note_item(sas_pkg::op_e op_v, logic [sas_pkg::TR_W-1:0] tr,
                            logic [sas_pkg::FIRST_W-1:0] start,
                            logic [sas_pkg::SPAN_W-1:0] span,
                            logic [sas_pkg::WORD_BITS-1:0] bits);
      sas_pkg::res_t answer;
      int            last;
      int            n;
      int            pkt;
      answer = '0;
      last   = int'(start) + int'(span);
      if (int'(tr) >= NUM_TR) begin
        answer.status = 1'b1;
      end else if (op_v == sas_pkg::OP_MARK) begin
        // only the low 64 bits count, and only packets inside the transfer
        n = (int'(span) > MARK_MAX) ? MARK_MAX : int'(span);
        answer.status = (int'(span) > MARK_MAX) || (last > PKTS);
        for (int i = 0; i < n; i++) begin
          pkt = int'(start) + i;
          if (bits[i] && pkt < PKTS)
            bitmap[tr][pkt / sas_pkg::WORD_BITS][pkt % sas_pkg::WORD_BITS] = 1'b1;
        end
      end else if (last > PKTS) begin
        answer.status = 1'b1;
      end else begin
        // empty range stays acknowledged
        answer.range_acked = 1'b1;
        for (int i = 0; i < int'(span); i++) begin
          pkt = int'(start) + i;
          if (!bitmap[tr][pkt / sas_pkg::WORD_BITS][pkt % sas_pkg::WORD_BITS]) begin
            answer.range_acked = 1'b0;
            break;
          end
        end
      end
      expected_answers.push_back(answer);
    endfunction

    // compare an accepted result beat with the oldest queued answer
    function void check_answer(logic status, logic range_acked);
      sas_pkg::res_t want;
      answers_seen++;
      if (expected_answers.size() == 0) begin
        fails++;
        if (fails <= MAX_LOG)
          $display("%0t: result with nothing queued, status %0b range_acked %0b",
                   $time, status, range_acked);
        return;
      end
      want = expected_answers.pop_front();
      if (status !== want.status) begin
        fails++;
        if (fails <= MAX_LOG)
          $display("%0t: status expected %0b actual %0b", $time, want.status, status);
      end
      if (range_acked !== want.range_acked) begin
        fails++;
        if (fails <= MAX_LOG)
          $display("%0t: range_acked expected %0b actual %0b", $time, want.range_acked,
                   range_acked);
      end
    endfunction
  endclass

endpackage

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 300;
  localparam int TAIL_CYCLES  = 100;
  localparam int SPAN_MAX     = (1 << sas_pkg::SPAN_W) - 1;
  localparam int NUM_TR       = ack_tb_pkg::NUM_TR;
  localparam int PKTS         = ack_tb_pkg::PKTS;
  localparam int WORDS        = ack_tb_pkg::WORDS;
  localparam int MARK_MAX     = ack_tb_pkg::MARK_MAX;
  localparam int WB           = sas_pkg::WORD_BITS;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [sas_pkg::OP_W-1:0]      op;
  logic [sas_pkg::TR_W-1:0]      transfer;
  logic [sas_pkg::FIRST_W-1:0]   start_pkt;
  logic [sas_pkg::SPAN_W-1:0]    span;
  logic [WB-1:0]                 ack_bits;
  logic                          out_valid;
  logic                          out_stall;
  logic                          status;
  logic                          range_acked;

  ack_tb_pkg::sack_predictor predictor;
  int unsigned   cycles = 0;
  int            sent = 0;
  int            burst_left = 0;
  int            fill_next [NUM_TR];
  int            stall_mode = 0;
  int            mode_left = 0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;
  bit            paused = 1'b0;

  selective_ack_scoreboard i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .transfer_i     (transfer),
    .start_pkt_i    (start_pkt),
    .span_i         (span),
    .ack_bits_i     (ack_bits),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .range_acked_o  (range_acked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check accepted beats, stall in changing modes plus one long hold
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) predictor.check_answer(status, range_acked);
      if (!hold_done && predictor.answers_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // random gap after a burst of beats, otherwise keep valid high
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  // offer one input beat and hold it until accepted
  task automatic send_item(sas_pkg::op_e op_v, int tr_v, int start_v, int span_v,
                           logic [WB-1:0] bits_v);
    logic [sas_pkg::TR_W-1:0]    tr_b;
    logic [sas_pkg::FIRST_W-1:0] start_b;
    logic [sas_pkg::SPAN_W-1:0]  span_b;
    tr_b    = sas_pkg::TR_W'(tr_v);
    start_b = sas_pkg::FIRST_W'(start_v);
    span_b  = sas_pkg::SPAN_W'(span_v);
    in_valid  <= 1'b1;
    op        <= op_v;
    transfer  <= tr_b;
    start_pkt <= start_b;
    span      <= span_b;
    ack_bits  <= bits_v;
    do @(posedge clk); while (in_stall);
    predictor.note_item(op_v, tr_b, start_b, span_b, bits_v);
    sent++;
    pace();
  endtask

  // stop offering until every queued answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  // edges of the fields and each error case
  task automatic directed();
    logic [WB-1:0] ones;
    ones = '1;
    send_item(sas_pkg::OP_CHECK, 0, 0, 64, ones);
    send_item(sas_pkg::OP_MARK, 0, 0, 64, ones);
    send_item(sas_pkg::OP_CHECK, 0, 0, 64, '0);
    send_item(sas_pkg::OP_CHECK, 0, PKTS - 1, 0, '0);
    send_item(sas_pkg::OP_CHECK, 0, 100, 0, '0);
    // mark straddling a word boundary
    send_item(sas_pkg::OP_MARK, 15, 60, 10, 64'h3ff);
    send_item(sas_pkg::OP_CHECK, 15, 60, 10, '0);
    send_item(sas_pkg::OP_CHECK, 15, 59, 11, '0);
    // mark running past the end of the transfer
    send_item(sas_pkg::OP_MARK, 15, PKTS - 6, 10, ones);
    send_item(sas_pkg::OP_CHECK, 15, PKTS - 6, 6, '0);
    send_item(sas_pkg::OP_CHECK, 15, PKTS - 6, 7, '0);
    // mark span over 64 and the widest span
    send_item(sas_pkg::OP_MARK, 7, 0, 65, ones);
    send_item(sas_pkg::OP_CHECK, 7, 0, 64, '0);
    send_item(sas_pkg::OP_MARK, 7, 64, SPAN_MAX, 64'h5555_5555_5555_5555);
    send_item(sas_pkg::OP_CHECK, 7, 64, 64, '0);
    send_item(sas_pkg::OP_MARK, 3, PKTS - 1, 0, ones);
    // whole transfer checks and ranges past capacity
    send_item(sas_pkg::OP_CHECK, 3, 0, PKTS, '0);
    send_item(sas_pkg::OP_CHECK, 0, 0, PKTS, '0);
    send_item(sas_pkg::OP_CHECK, 0, 1, PKTS, '0);
    send_item(sas_pkg::OP_CHECK, 0, PKTS - 1, SPAN_MAX, ones);
    send_item(sas_pkg::OP_MARK, 0, 0, PKTS, '0);
    send_item(sas_pkg::OP_CHECK, 5, PKTS - 1, 1, '0);
    send_item(sas_pkg::OP_MARK, 5, PKTS - 1, 1, 64'h1);
    send_item(sas_pkg::OP_CHECK, 5, PKTS - 1, 1, '0);
  endtask

  // mark one chunk, then check it and maybe part of it
  task automatic chunk_run();
    int            tr;
    int            first;
    int            cnt;
    int            lo;
    int            part;
    logic [WB-1:0] mask;
    logic [WB-1:0] bits;
    tr    = $urandom_range(0, NUM_TR - 1);
    first = $urandom_range(0, 1) ? $urandom_range(0, WORDS - 1) * WB
                                 : $urandom_range(0, PKTS - 1);
    cnt   = $urandom_range(1, MARK_MAX);
    if (first + cnt > PKTS) cnt = PKTS - first;
    mask = (cnt == WB) ? '1 : ((64'd1 << cnt) - 64'd1);
    bits = mask;
    if ($urandom_range(0, 3) == 0) bits[$urandom_range(0, cnt - 1)] = 1'b0;
    if ($urandom_range(0, 4) == 0) bits = bits | (~mask & {$urandom, $urandom});
    send_item(sas_pkg::OP_MARK, tr, first, cnt, bits);
    send_item(sas_pkg::OP_CHECK, tr, first, cnt, {$urandom, $urandom});
    if ($urandom_range(0, 2) == 0) begin
      lo   = $urandom_range(0, cnt - 1);
      part = $urandom_range(0, cnt - lo);
      send_item(sas_pkg::OP_CHECK, tr, first + lo, part, {$urandom, $urandom});
    end
  endtask

  // fill a low transfer chunk by chunk, then check it whole
  task automatic fill_run();
    int tr;
    tr = $urandom_range(0, 3);
    repeat (8) begin
      if (fill_next[tr] < WORDS) begin
        send_item(sas_pkg::OP_MARK, tr, fill_next[tr] * WB, WB, '1);
        fill_next[tr]++;
      end
    end
    send_item(sas_pkg::OP_CHECK, tr, 0, PKTS, {$urandom, $urandom});
  endtask

  // any field values, mostly short spans
  task automatic noise_item();
    int pick;
    int cnt;
    pick = $urandom_range(0, 19);
    cnt  = (pick < 12) ? $urandom_range(0, MARK_MAX) :
           (pick < 17) ? $urandom_range(0, PKTS) : $urandom_range(0, SPAN_MAX);
    send_item(sas_pkg::op_e'($urandom_range(0, 1)), $urandom_range(0, NUM_TR - 1),
              $urandom_range(0, PKTS - 1), cnt, {$urandom, $urandom});
  endtask

  // stimulus
  initial begin
    int pick;
    predictor = new();
    foreach (fill_next[t]) fill_next[t] = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    op        <= sas_pkg::OP_MARK;
    transfer  <= '0;
    start_pkt <= '0;
    span      <= '0;
    ack_bits  <= '0;
    out_stall <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    directed();
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) chunk_run();
      else if (pick < 65) fill_run();
      else repeat ($urandom_range(1, 3)) noise_item();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predictor.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
